FILE: rtl/lwph_pkg.sv
// shared types, constants and codes for the line walk point hit search unit
package lwph_pkg;

  localparam int COORD_W   = 12;
  localparam int SHIFT_W   = 10;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int WALK_W    = COORD_W + 1;
  localparam int LOOK_W    = WALK_W + 1;
  localparam int ERR_W     = COORD_W + 4;
  localparam int CFG_IDX_W = 2;
  localparam int ROWS_DEF  = 512;
  localparam int COLS_DEF  = 512;

  typedef enum logic [1:0] {
    OP_SET     = 2'd0,
    OP_CLR     = 2'd1,
    OP_CLR_ALL = 2'd2,
    OP_SEARCH  = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_SHIFT = 2'd0,
    CFG_COL_SHIFT = 2'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP1,
    ST_SETUP2,
    ST_WALK,
    ST_FINISH
  } st_e;

  typedef struct packed {
    op_e                        op;
    logic signed [COORD_W-1:0]  first_row;
    logic signed [COORD_W-1:0]  first_col;
    logic signed [COORD_W-1:0]  second_row;
    logic signed [COORD_W-1:0]  second_col;
  } in_word_t;

  typedef struct packed {
    logic                       found;
    logic signed [COORD_W-1:0]  hit_row;
    logic signed [COORD_W-1:0]  hit_col;
  } out_word_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [SHIFT_W-1:0]   value;
  } cfg_word_t;

  typedef struct packed {
    logic wr_pix;
    logic capture;
    logic setup1;
    logic setup2;
    logic step;
    logic res_load;
    logic res_push;
    logic clr_step;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic a_vld;
    logic b_vld;
    logic hit;
    logic out_free;
    logic clr_last;
  } sts_t;

endpackage

FILE: rtl/lwph_ifs.sv
// valid/ready channel interfaces for item, result and configuration words
interface lwph_in_if import lwph_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lwph_out_if import lwph_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lwph_cfg_if import lwph_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/lwph_ctrl.sv
// controller state machine: sequences clear sweeps, pixel writes and line walks
module lwph_ctrl import lwph_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  op_e  op_i,
  input  sts_t sts_i,
  output logic in_ready_o,
  output cmd_t cmd_o
);

  st_e  state_q, state_d;
  logic walk_end;

  assign walk_end = sts_i.hit || (sts_i.cnt_zero && !sts_i.a_vld && !sts_i.b_vld);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (op_i)
            OP_CLR_ALL: state_d = ST_CLEAR;
            OP_SEARCH:  state_d = ST_SETUP1;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_SETUP1: state_d = ST_SETUP2;
      ST_SETUP2: state_d = ST_WALK;
      ST_WALK: begin
        if (walk_end) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clr_step = 1'b1;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (op_i)
            OP_SET, OP_CLR: cmd_o.wr_pix  = 1'b1;
            OP_SEARCH:      cmd_o.capture = 1'b1;
            default:        cmd_o.wr_pix  = 1'b0;
          endcase
        end
      end
      ST_SETUP1: cmd_o.setup1 = 1'b1;
      ST_SETUP2: cmd_o.setup2 = 1'b1;
      ST_WALK: begin
        cmd_o.step     = !sts_i.cnt_zero && !sts_i.hit;
        cmd_o.res_load = walk_end;
      end
      ST_FINISH: cmd_o.res_push = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  a_step_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |-> !sts_i.cnt_zero)
    else $error("walk step issued with no pixels left");

  a_pipe_empty_at_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SETUP2 |=> !sts_i.a_vld && !sts_i.b_vld)
    else $error("lookup pipeline not empty when walk starts");

  a_hit_ends_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK && sts_i.hit) |=> state_q == ST_FINISH)
    else $error("hit did not end the walk");

  a_push_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_push |-> sts_i.out_free)
    else $error("result pushed into a full output register");

endmodule

FILE: rtl/lwph_dp.sv
// datapath: bitmap memory, line stepper, shifted lookup pipeline and output register
module lwph_dp import lwph_pkg::*; #(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  output sts_t      sts_o,
  input  in_word_t  in_word_i,
  input  logic      cfg_valid_i,
  input  cfg_word_t cfg_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  localparam int ROW_AW = $clog2(ROWS);
  localparam int COL_AW = $clog2(COLS);

  // bitmap, one row of pixels per word
  logic [COLS-1:0] mem_q [ROWS];
  logic [COLS-1:0] rdata_q;

  logic [SHIFT_W-1:0] row_shift_q, col_shift_q;
  logic [ROW_AW-1:0]  clr_cnt_q, clr_cnt_d;
  in_word_t           in_q;

  // pixel write
  logic [COORD_W-1:0] pr, pc;
  logic               pix_in;

  // setup
  logic [DIFF_W-1:0]  dr_s, dc_s, dr_q, dc_q;
  logic [COORD_W-1:0] adr_q, adc_q;
  logic               rm, swap, inc_pos;
  logic [COORD_W-1:0] dmaj, dmin;
  logic [DIFF_W-1:0]  dmin_s;
  logic [COORD_W-1:0] maj_a, maj_b, mnr_a, mnr_b, k_sel, m_sel;
  logic [ERR_W-1:0]   e_lo, e_hi, p0;

  // stepper
  logic               rm_q, inc_q;
  logic [ERR_W-1:0]   e_lo_q, e_hi_q, p_q, p_next;
  logic [WALK_W-1:0]  k_q, m_q, m_step;
  logic [COORD_W-1:0] cnt_q;
  logic               a_vld_q;
  logic [WALK_W-1:0]  a_row_q, a_col_q;

  // lookup
  logic [LOOK_W-1:0]  rr, cc;
  logic               look_in;
  logic [ROW_AW-1:0]  raddr;
  logic [COL_AW-1:0]  cidx;
  logic               b_vld_q, b_in_q;
  logic [WALK_W-1:0]  b_row_q, b_col_q;
  logic [COL_AW-1:0]  b_cidx_q;
  logic               hit;

  // result and output
  logic               res_found_q;
  logic [COORD_W-1:0] res_row_q, res_col_q;
  logic               out_vld_q;
  out_word_t          out_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_shift_q <= '0;
      col_shift_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_word_i.index)
        CFG_ROW_SHIFT: row_shift_q <= cfg_word_i.value;
        CFG_COL_SHIFT: col_shift_q <= cfg_word_i.value;
        default:       row_shift_q <= row_shift_q;
      endcase
    end
  end

  // clear sweep counter
  assign clr_cnt_d = (clr_cnt_q == ROW_AW'(ROWS - 1)) ? '0 : clr_cnt_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // set or clear one pixel, unshifted
  assign pr     = in_word_i.first_row;
  assign pc     = in_word_i.first_col;
  assign pix_in = !pr[COORD_W-1] && !pc[COORD_W-1] &&
                  (pr < COORD_W'(ROWS)) && (pc < COORD_W'(COLS));

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      mem_q[clr_cnt_q] <= '0;
    end else if (cmd_i.wr_pix && pix_in) begin
      mem_q[pr[ROW_AW-1:0]][pc[COL_AW-1:0]] <= (in_word_i.op == OP_SET);
    end
    rdata_q <= mem_q[raddr];
  end

  // setup stage one: signed and absolute differences
  assign dr_s = {in_q.second_row[COORD_W-1], in_q.second_row} -
                {in_q.first_row[COORD_W-1], in_q.first_row};
  assign dc_s = {in_q.second_col[COORD_W-1], in_q.second_col} -
                {in_q.first_col[COORD_W-1], in_q.first_col};

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= in_word_i;
    end
    if (cmd_i.setup1) begin
      dr_q  <= dr_s;
      dc_q  <= dc_s;
      adr_q <= dr_s[DIFF_W-1] ? COORD_W'(-dr_s) : dr_s[COORD_W-1:0];
      adc_q <= dc_s[DIFF_W-1] ? COORD_W'(-dc_s) : dc_s[COORD_W-1:0];
    end
  end

  // setup stage two: axis choice, swap, decision term
  assign rm      = (adc_q <= adr_q);
  assign dmaj    = rm ? adr_q : adc_q;
  assign dmin    = rm ? adc_q : adr_q;
  assign swap    = rm ? dr_q[DIFF_W-1] : dc_q[DIFF_W-1];
  assign dmin_s  = rm ? dc_q : dr_q;
  assign inc_pos = swap ? dmin_s[DIFF_W-1] : (!dmin_s[DIFF_W-1] && (dmin_s != '0));
  assign maj_a   = rm ? in_q.first_row  : in_q.first_col;
  assign maj_b   = rm ? in_q.second_row : in_q.second_col;
  assign mnr_a   = rm ? in_q.first_col  : in_q.first_row;
  assign mnr_b   = rm ? in_q.second_col : in_q.second_row;
  assign k_sel   = swap ? maj_b : maj_a;
  assign m_sel   = swap ? mnr_b : mnr_a;
  assign e_lo    = {(ERR_W - COORD_W - 1)'(0), dmin, 1'b0};
  assign e_hi    = e_lo - {(ERR_W - COORD_W - 1)'(0), dmaj, 1'b0};
  assign p0      = e_lo - {(ERR_W - COORD_W)'(0), dmaj};

  // one pixel per step
  assign m_step = p_q[ERR_W-1] ? m_q : (inc_q ? m_q + 1'b1 : m_q - 1'b1);
  assign p_next = p_q + (p_q[ERR_W-1] ? e_lo_q : e_hi_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup2) begin
      rm_q   <= rm;
      inc_q  <= inc_pos;
      e_lo_q <= e_lo;
      e_hi_q <= e_hi;
      p_q    <= p0;
      k_q    <= {k_sel[COORD_W-1], k_sel};
      m_q    <= {m_sel[COORD_W-1], m_sel};
      cnt_q  <= dmaj;
    end else if (cmd_i.step) begin
      p_q     <= p_next;
      m_q     <= m_step;
      k_q     <= k_q + 1'b1;
      cnt_q   <= cnt_q - 1'b1;
      a_row_q <= rm_q ? k_q : m_step;
      a_col_q <= rm_q ? m_step : k_q;
    end
  end

  // shifted lookup address
  assign rr = {a_row_q[WALK_W-1], a_row_q} +
              {{(LOOK_W - SHIFT_W){row_shift_q[SHIFT_W-1]}}, row_shift_q};
  assign cc = {a_col_q[WALK_W-1], a_col_q} +
              {{(LOOK_W - SHIFT_W){col_shift_q[SHIFT_W-1]}}, col_shift_q};
  assign look_in = !rr[LOOK_W-1] && !cc[LOOK_W-1] &&
                   (rr < LOOK_W'(ROWS)) && (cc < LOOK_W'(COLS));
  assign raddr = look_in ? rr[ROW_AW-1:0] : '0;
  assign cidx  = look_in ? cc[COL_AW-1:0] : '0;

  always_ff @(posedge clk_i) begin
    b_row_q  <= a_row_q;
    b_col_q  <= a_col_q;
    b_in_q   <= look_in;
    b_cidx_q <= cidx;
  end

  assign hit = b_vld_q && b_in_q && rdata_q[b_cidx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      a_vld_q <= cmd_i.step;
      b_vld_q <= a_vld_q && !hit;
    end
  end

  // result and output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_found_q <= hit;
      res_row_q   <= hit ? b_row_q[COORD_W-1:0] : '0;
      res_col_q   <= hit ? b_col_q[COORD_W-1:0] : '0;
    end
    if (cmd_i.res_push) begin
      out_q.found   <= res_found_q;
      out_q.hit_row <= res_row_q;
      out_q.hit_col <= res_col_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.res_push) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

  assign sts_o.cnt_zero = (cnt_q == '0);
  assign sts_o.a_vld    = a_vld_q;
  assign sts_o.b_vld    = b_vld_q;
  assign sts_o.hit      = hit;
  assign sts_o.out_free = !out_vld_q || out_ready_i;
  assign sts_o.clr_last = (clr_cnt_q == ROW_AW'(ROWS - 1));

endmodule

FILE: rtl/line_walk_point_hit_search_unit.sv
// top level: line walk first hit search over a contour bitmap
// set and clear pixel words write a single pixel; clear all sweeps every bitmap row, one bitmap row a cycle
// a search ends early when a walked pixel hits; a degenerate line is not walked at all
// dmaj is the major axis length; the stepper gives one pixel a cycle, and the bitmap read is registered behind it
// after reset a clearing pass over all bitmap rows runs before the first item is taken
// configuration words are taken in any cycle; a waiting result holds the next search at its end
module line_walk_point_hit_search_unit import lwph_pkg::*; #(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lwph_in_if.sink     in_i,
  lwph_out_if.source  out_o,
  lwph_cfg_if.sink    cfg_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_i.ready = 1'b1;

  lwph_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .op_i       (in_i.data.op),
    .sts_i      (sts),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd)
  );

  lwph_dp #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_word_i   (in_i.data),
    .cfg_valid_i (cfg_i.valid),
    .cfg_word_i  (cfg_i.data),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_word_o  (out_o.data)
  );

endmodule

FILE: tb/line_walk_point_hit_search_unit_checker.sv
// checker for the line walk hit search unit: bitmap and shift predictor, result compare
module hit_search_checker import lwph_pkg::*; #(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  lwph_in_if    item_i,
  lwph_out_if   result_i,
  lwph_cfg_if   cfg_i,
  output int    fail_count_o,
  output int    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  bit [COLS-1:0] marks [ROWS];
  int            row_off = 0;
  int            col_off = 0;
  int            fails = 0;
  out_word_t     pending_hits [$];

  function automatic int sx(logic [COORD_W-1:0] v);
    return int'($signed(v));
  endfunction

  function automatic bit in_map(int r, int c);
    return r >= 0 && r < ROWS && c >= 0 && c < COLS;
  endfunction

  function automatic bit marked_at(int r, int c);
    int rr, cc;
    rr = r + row_off;
    cc = c + col_off;
    if (!in_map(rr, cc)) return 1'b0;
    return marks[rr][cc];
  endfunction

  // bresenham walk from the lower major coordinate, upper endpoint excluded
  function automatic out_word_t trace_line(int r1, int c1, int r2, int c2);
    int dr, dc, maj0, mnr0, maj1, mnr1, t, dmaj, dmin, err, inc, k, mnr;
    bit rows_major;
    out_word_t res;
    res = '0;
    dr = (r2 >= r1) ? r2 - r1 : r1 - r2;
    dc = (c2 >= c1) ? c2 - c1 : c1 - c2;
    rows_major = (dc <= dr);
    if (rows_major) begin
      maj0 = r1; mnr0 = c1; maj1 = r2; mnr1 = c2;
    end else begin
      maj0 = c1; mnr0 = r1; maj1 = c2; mnr1 = r2;
    end
    if (maj1 < maj0) begin
      t = maj0; maj0 = maj1; maj1 = t;
      t = mnr0; mnr0 = mnr1; mnr1 = t;
    end
    dmaj = maj1 - maj0;
    dmin = (mnr1 >= mnr0) ? mnr1 - mnr0 : mnr0 - mnr1;
    inc = (mnr0 < mnr1) ? 1 : -1;
    err = 2 * dmin - dmaj;
    mnr = mnr0;
    for (k = maj0; k < maj1; k++) begin
      if (err < 0) begin
        err += 2 * dmin;
      end else begin
        err += 2 * (dmin - dmaj);
        mnr += inc;
      end
      if (rows_major ? marked_at(k, mnr) : marked_at(mnr, k)) begin
        res.found = 1'b1;
        res.hit_row = COORD_W'(rows_major ? k : mnr);
        res.hit_col = COORD_W'(rows_major ? mnr : k);
        return res;
      end
    end
    return res;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i) begin
    out_word_t want;
    in_word_t  w;
    int        r, c;
    if (rst_ni) begin
      if (result_i.valid === 1'b1 && result_i.ready === 1'b1) begin
        if (pending_hits.size() == 0) begin
          $error("result word with no search outstanding");
          fails++;
        end else begin
          want = pending_hits.pop_front();
          if (result_i.data.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, result_i.data.found);
            fails++;
          end
          check_field("hit_row", sx(want.hit_row), sx(result_i.data.hit_row));
          check_field("hit_col", sx(want.hit_col), sx(result_i.data.hit_col));
        end
      end
      if (cfg_i.valid === 1'b1 && cfg_i.ready === 1'b1) begin
        case (cfg_reg_e'(cfg_i.data.index))
          CFG_ROW_SHIFT: row_off = int'($signed(cfg_i.data.value));
          CFG_COL_SHIFT: col_off = int'($signed(cfg_i.data.value));
          default: ;
        endcase
      end
      if (item_i.valid === 1'b1 && item_i.ready === 1'b1) begin
        w = item_i.data;
        r = sx(w.first_row);
        c = sx(w.first_col);
        case (w.op)
          OP_SET: if (in_map(r, c)) marks[r][c] = 1'b1;
          OP_CLR: if (in_map(r, c)) marks[r][c] = 1'b0;
          OP_CLR_ALL: foreach (marks[i]) marks[i] = '0;
          OP_SEARCH: begin
            pending_hits.push_back(trace_line(r, c, sx(w.second_row), sx(w.second_col)));
          end
          default: ;
        endcase
      end
    end
    fail_count_o <= fails;
    pending_o <= pending_hits.size();
  end

endmodule

FILE: tb/line_walk_point_hit_search_unit_tb.sv
// testbench top: stimulus, handshake pacing and verdict for the line walk hit search unit
module line_walk_point_hit_search_unit_tb import lwph_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLEAR_WAIT     = ROWS_DEF + 64;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 140;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   idle_cycles = 0;
  int   row_sh = 0;
  int   col_sh = 0;
  bit   steady = 1'b0;

  lwph_in_if  item_w ();
  lwph_out_if result_w ();
  lwph_cfg_if cfg_w ();

  line_walk_point_hit_search_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (item_w),
    .out_o  (result_w),
    .cfg_i  (cfg_w)
  );

  hit_search_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item_w),
    .result_i     (result_w),
    .cfg_i        (cfg_w),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(99);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 16);
    return $urandom_range(40, 150);
  endfunction

  function automatic int clip(int v);
    if (v < -2048) return -2048;
    if (v > 2047) return 2047;
    return v;
  endfunction

  function automatic int any_coord();
    return int'($urandom_range(4095)) - 2048;
  endfunction

  function automatic in_word_t make_word(op_e op, int r1, int c1, int r2, int c2);
    in_word_t w;
    w.op = op;
    w.first_row = COORD_W'(r1);
    w.first_col = COORD_W'(c1);
    w.second_row = COORD_W'(r2);
    w.second_col = COORD_W'(c2);
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    int gap;
    item_w.valid <= 1'b1;
    item_w.data <= w;
    do @(posedge clk_i); while (item_w.ready !== 1'b1);
    gap = pick_gap();
    if (gap > 0) begin
      item_w.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold off until no search is outstanding, then wait extra, which lets a clear pass finish when extra is CLEAR_WAIT
  task automatic settle(int extra);
    if (item_w.valid) item_w.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, int val);
    cfg_w.valid <= 1'b1;
    cfg_w.data <= {idx, SHIFT_W'(val)};
    do @(posedge clk_i); while (cfg_w.ready !== 1'b1);
    cfg_w.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_phase(int count);
    int base_r, base_c, kind, span, r1, c1, r2, c2;
    op_e op;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        base_r = $urandom_range(ROWS_DEF - 32);
        base_c = $urandom_range(COLS_DEF - 32);
        steady = ($urandom_range(3) == 0);
      end
      kind = $urandom_range(99);
      r1 = base_r + $urandom_range(31);
      c1 = base_c + $urandom_range(31);
      r2 = any_coord();
      c2 = any_coord();
      op = OP_SEARCH;
      if (kind < 34) begin
        op = OP_SET;
      end else if (kind < 42) begin
        op = OP_CLR;
      end else if (kind < 45) begin
        op = $urandom_range(1) ? OP_CLR : OP_SET;
        r1 = any_coord();
        c1 = any_coord();
      end else if (kind < 46) begin
        op = OP_CLR_ALL;
      end else if (kind < 92) begin
        // aim at the marked window as seen through the shifts
        span = ($urandom_range(9) == 0) ? 200 : 24;
        r1 = clip(r1 - row_sh + $urandom_range(16) - 8);
        c1 = clip(c1 - col_sh + $urandom_range(16) - 8);
        r2 = clip(r1 + $urandom_range(2 * span) - span);
        c2 = clip(c1 + $urandom_range(2 * span) - span);
      end else if (kind < 97) begin
        r1 = any_coord();
        c1 = any_coord();
        r2 = clip(r1 + $urandom_range(64) - 32);
        c2 = clip(c1 + $urandom_range(64) - 32);
      end else begin
        r1 = any_coord();
        c1 = any_coord();
      end
      send_word(make_word(op, r1, c1, r2, c2));
      if ($urandom_range(99) == 0) settle(0);
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    item_w.valid <= 1'b0;
    item_w.data <= '0;
    cfg_w.valid <= 1'b0;
    cfg_w.data <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // corners, out of range writes, degenerate and extreme lines
    send_word(make_word(OP_SET, 0, 0, any_coord(), any_coord()));
    send_word(make_word(OP_SET, 511, 511, any_coord(), any_coord()));
    send_word(make_word(OP_SET, 0, 511, any_coord(), any_coord()));
    send_word(make_word(OP_SET, 511, 0, any_coord(), any_coord()));
    send_word(make_word(OP_SET, -1, 5, 0, 0));
    send_word(make_word(OP_SET, 512, 511, 0, 0));
    send_word(make_word(OP_SET, 2047, -2048, 0, 0));
    send_word(make_word(OP_SEARCH, 5, 5, 5, 5));
    send_word(make_word(OP_SEARCH, -1, -1, 2047, 2047));
    send_word(make_word(OP_SEARCH, -2048, -2048, 2047, 2047));
    send_word(make_word(OP_SEARCH, 2047, -2048, -2048, 2047));
    send_word(make_word(OP_SEARCH, 0, -5, 0, 20));
    send_word(make_word(OP_SEARCH, 20, 511, -3, 511));
    send_word(make_word(OP_SEARCH, 511, -10, 511, 600));
    send_word(make_word(OP_CLR, 0, 0, any_coord(), any_coord()));
    send_word(make_word(OP_SEARCH, 0, -5, 0, 20));
    send_word(make_word(OP_SET, 100, 200, 0, 0));
    send_word(make_word(OP_SEARCH, 95, 200, 105, 200));
    send_word(make_word(OP_SEARCH, 100, 150, 103, 260));
    send_word(make_word(OP_CLR_ALL, any_coord(), any_coord(), any_coord(), any_coord()));
    send_word(make_word(OP_SEARCH, 95, 200, 105, 200));
    send_word(make_word(OP_SET, 3, 4, -1, -1));
    send_word(make_word(OP_SEARCH, 2, 4, 4, 4));
    send_word(make_word(OP_CLR, -2048, -2048, 0, 0));

    for (int ph = 0; ph < PHASES; ph++) begin
      settle(CLEAR_WAIT);
      case (ph)
        0: begin row_sh = 511; col_sh = -512; end
        1: begin row_sh = -512; col_sh = 511; end
        2: begin row_sh = 0; col_sh = 0; end
        5: begin row_sh = -512; col_sh = -512; end
        default: begin
          row_sh = int'($urandom_range(1023)) - 512;
          col_sh = int'($urandom_range(1023)) - 512;
        end
      endcase
      write_reg(CFG_ROW_SHIFT, row_sh);
      write_reg(CFG_COL_SHIFT, col_sh);
      run_phase(PHASE_ITEMS);
    end

    settle(CLEAR_WAIT);
    if (fail_count == 0)
      $display("line_walk_point_hit_search_unit verification clean");
    else
      $display("line_walk_point_hit_search_unit verification failed");
    $finish;
  end

  initial begin
    int gap;
    forever begin
      result_w.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        result_w.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (item_w.valid && item_w.ready) || (result_w.valid && result_w.ready)
        || (cfg_w.valid && cfg_w.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("line_walk_point_hit_search_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

FILE: line_walk_point_hit_search_unit.f
rtl/lwph_pkg.sv
rtl/lwph_ifs.sv
rtl/lwph_ctrl.sv
rtl/lwph_dp.sv
rtl/line_walk_point_hit_search_unit.sv
tb/line_walk_point_hit_search_unit_checker.sv
tb/line_walk_point_hit_search_unit_tb.sv
